// ----- sv/msfd_pkg.sv -----
`timescale 1ns / 1ps

package msfd_pkg;

  localparam logic [7:0] MAGIC_FIRST  = 8'h4D;
  localparam logic [7:0] MAGIC_SECOND = 8'hFE;
  localparam int unsigned HEADER_BYTES = 9;
  localparam logic [3:0] HEADER_LAST = 4'(HEADER_BYTES - 1);

  localparam logic [7:0]  VERSION_RESET = 8'd1;
  localparam logic [15:0] MAX_LEN_RESET = 16'd512;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CHECK   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_TRAILER = 2'd2,
    KIND_REJECT  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_VERSION = 2'd1,
    ERR_LENGTH  = 2'd2
  } err_t;

  typedef enum logic {
    REG_EXPECTED_VERSION = 1'b0,
    REG_MAX_PAYLOAD_LEN  = 1'b1
  } reg_index_t;

endpackage

// ----- sv/magic_sync_frame_deframer.sv -----
`timescale 1ns / 1ps

// Byte-stream frame parser. One byte is taken per clock while in_stall is low;
// a byte passes from the input register through the parse logic into the
// result register, and the pipe keeps one byte per cycle as long as out_stall
// is low. in_stall rises only when both the input register and the result
// register are full and the result is stalled. The parser hunts for 0x4D
// 0xFE, collects a nine-byte little-endian header and gives one header result
// (or one rejection, marked last), one result per payload byte, and one
// trailer carrying the check word, marked last. Configuration registers take
// effect on the next header checked.
module magic_sync_frame_deframer (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [1:0]  error_code,
  output logic [7:0]  version_seen,
  output logic [15:0] station_num,
  output logic [31:0] timestamp,
  output logic [15:0] payload_length,
  output logic [7:0]  data_byte,
  output logic [15:0] check_word,
  output logic        frame_last,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [7:0]  expected_version;
  logic [15:0] max_payload_length;

  logic        r_valid;
  logic [7:0]  r_byte;

  msfd_pkg::phase_t phase, phase_next;
  logic        saw_first, saw_first_next;
  logic [15:0] byte_cnt, byte_cnt_next;
  logic [7:0]  hdr [msfd_pkg::HEADER_BYTES];
  logic [7:0]  check_low;

  logic        out_free;
  logic        go;
  logic        emit;
  logic        hdr_we;
  logic        check_we;
  logic [1:0]  kind_next;
  logic [1:0]  err_next;
  logic [7:0]  version_next;
  logic [15:0] station_next;
  logic [31:0] timestamp_next;
  logic [15:0] length_next;
  logic [7:0]  data_next;
  logic [15:0] check_next;
  logic        last_next;

  logic [15:0] hdr_len;
  logic [15:0] stored_len;
  logic [15:0] cnt_inc;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign go        = r_valid && out_free;
  assign in_stall  = r_valid && !out_free;

  assign hdr_len    = {r_byte, hdr[7]};
  assign stored_len = {hdr[8], hdr[7]};
  assign cnt_inc    = byte_cnt + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version   <= msfd_pkg::VERSION_RESET;
      max_payload_length <= msfd_pkg::MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        msfd_pkg::REG_EXPECTED_VERSION: expected_version   <= cfg_data[7:0];
        msfd_pkg::REG_MAX_PAYLOAD_LEN:  max_payload_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (!in_stall) begin
      r_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      r_byte <= in_byte;
    end
  end

  always_comb begin
    phase_next     = phase;
    saw_first_next = saw_first;
    byte_cnt_next  = byte_cnt;
    emit           = 1'b0;
    hdr_we         = 1'b0;
    check_we       = 1'b0;
    kind_next      = msfd_pkg::KIND_HEADER;
    err_next       = msfd_pkg::ERR_NONE;
    version_next   = '0;
    station_next   = '0;
    timestamp_next = '0;
    length_next    = '0;
    data_next      = '0;
    check_next     = '0;
    last_next      = 1'b0;
    case (phase)
      msfd_pkg::PH_HUNT: begin
        if (saw_first && r_byte == msfd_pkg::MAGIC_SECOND) begin
          phase_next     = msfd_pkg::PH_HEADER;
          byte_cnt_next  = '0;
          saw_first_next = 1'b0;
        end else begin
          saw_first_next = (r_byte == msfd_pkg::MAGIC_FIRST);
        end
      end
      msfd_pkg::PH_HEADER: begin
        hdr_we        = 1'b1;
        byte_cnt_next = cnt_inc;
        if (byte_cnt[3:0] == msfd_pkg::HEADER_LAST) begin
          emit           = 1'b1;
          byte_cnt_next  = '0;
          version_next   = hdr[0];
          station_next   = {hdr[2], hdr[1]};
          timestamp_next = {hdr[6], hdr[5], hdr[4], hdr[3]};
          length_next    = hdr_len;
          if (hdr[0] != expected_version) begin
            err_next = msfd_pkg::ERR_VERSION;
          end else if (hdr_len > max_payload_length) begin
            err_next = msfd_pkg::ERR_LENGTH;
          end
          if (err_next != msfd_pkg::ERR_NONE) begin
            kind_next      = msfd_pkg::KIND_REJECT;
            last_next      = 1'b1;
            phase_next     = msfd_pkg::PH_HUNT;
            saw_first_next = 1'b0;
          end else begin
            kind_next  = msfd_pkg::KIND_HEADER;
            phase_next = (hdr_len == '0) ? msfd_pkg::PH_CHECK : msfd_pkg::PH_PAYLOAD;
          end
        end
      end
      msfd_pkg::PH_PAYLOAD: begin
        emit          = 1'b1;
        kind_next     = msfd_pkg::KIND_PAYLOAD;
        data_next     = r_byte;
        byte_cnt_next = cnt_inc;
        if (cnt_inc >= stored_len) begin
          byte_cnt_next = '0;
          phase_next    = msfd_pkg::PH_CHECK;
        end
      end
      msfd_pkg::PH_CHECK: begin
        if (byte_cnt == '0) begin
          check_we      = 1'b1;
          byte_cnt_next = 16'd1;
        end else begin
          emit           = 1'b1;
          kind_next      = msfd_pkg::KIND_TRAILER;
          check_next     = {r_byte, check_low};
          last_next      = 1'b1;
          byte_cnt_next  = '0;
          phase_next     = msfd_pkg::PH_HUNT;
          saw_first_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= msfd_pkg::PH_HUNT;
      saw_first <= 1'b0;
      byte_cnt  <= '0;
    end else if (go) begin
      phase     <= phase_next;
      saw_first <= saw_first_next;
      byte_cnt  <= byte_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && hdr_we) begin
      hdr[byte_cnt[3:0]] <= r_byte;
    end
    if (go && check_we) begin
      check_low <= r_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      kind           <= kind_next;
      error_code     <= err_next;
      version_seen   <= version_next;
      station_num    <= station_next;
      timestamp      <= timestamp_next;
      payload_length <= length_next;
      data_byte      <= data_next;
      check_word     <= check_next;
      frame_last     <= last_next;
    end
  end

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_last == (kind == msfd_pkg::KIND_TRAILER ||
                                  kind == msfd_pkg::KIND_REJECT)))
    else $error("frame_last disagrees with kind");

  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((error_code != msfd_pkg::ERR_NONE) == (kind == msfd_pkg::KIND_REJECT)))
    else $error("error_code disagrees with kind");

  a_last_hunt: assert property (@(posedge clk) disable iff (rst)
    (go && emit && last_next) |=> (phase == msfd_pkg::PH_HUNT && !saw_first))
    else $error("parser not hunting after end of frame");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (r_valid && out_valid && out_stall))
    else $error("input stalled without a stalled result");

endmodule
